// ----- src/qat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and constants for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

    // Token limit and counter width
    localparam int MAX_TOKENS  = 50;
    localparam int TOKEN_W     = 6;
    localparam logic [TOKEN_W-1:0] TOKEN_LIMIT = TOKEN_W'(MAX_TOKENS - 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_NUL    = 8'd0;
    localparam logic [7:0] CHAR_TAB    = 8'd9;
    localparam logic [7:0] CHAR_LF     = 8'd10;
    localparam logic [7:0] CHAR_SPACE  = 8'd32;
    localparam logic [7:0] CHAR_DQUOTE = 8'd34;
    localparam logic [7:0] CHAR_SQUOTE = 8'd39;
    localparam logic [7:0] SEP_RESET   = CHAR_SPACE;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Queued operations, each one or two results
    typedef enum logic [1:0] {
        OP_CHAR     = 2'd0,
        OP_END      = 2'd1,
        OP_DONE     = 2'd2,
        OP_END_DONE = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         ch;
        logic [TOKEN_W-1:0] number;
        logic [TOKEN_W-1:0] total;
        logic               trunc;
    } entry_t;

    // Scan mode state machine
    typedef enum logic [3:0] {
        MODE_SKIP    = 4'b0001,
        MODE_TOKEN   = 4'b0010,
        MODE_QUOTE   = 4'b0100,
        MODE_DISCARD = 4'b1000
    } mode_t;

endpackage

// ----- src/qat_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_front
// Accepts characters, classifies them, tracks scan mode and token count,
// and pushes result operations into the queue.
// ----------------------------------------------------------------------------
module qat_front
    import qat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_data,
    input  logic         accept,
    input  logic [7:0]   character,
    output logic         push,
    output entry_t       push_entry
);

    logic [7:0]         sep_reg;
    mode_t              mode_reg, mode_next;
    logic [TOKEN_W-1:0] started_reg, started_next;
    logic [TOKEN_W-1:0] cur;
    logic               eol, sep, quote;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= SEP_RESET;
        end
        else if (cfg_valid)
        begin
            sep_reg <= cfg_data;
        end
    end

    // Character classes
    assign eol   = (character == CHAR_NUL) || (character == CHAR_LF);
    assign sep   = (character == CHAR_SPACE) || (character == CHAR_TAB) ||
                   (character == sep_reg);
    assign quote = (character == CHAR_SQUOTE) || (character == CHAR_DQUOTE);
    assign cur   = started_reg - 1'b1;

    // Mode update and operation selection
    always_comb
    begin
        mode_next    = mode_reg;
        started_next = started_reg;
        push         = 1'b0;
        push_entry   = '0;
        if (accept)
        begin
            case (mode_reg)
                MODE_SKIP:
                begin
                    if (eol)
                    begin
                        push             = 1'b1;
                        push_entry.op    = OP_DONE;
                        push_entry.total = (started_reg != '0) ? started_reg
                                                               : TOKEN_W'(1);
                        started_next     = '0;
                    end
                    else if (sep)
                    begin
                        mode_next = MODE_SKIP;
                    end
                    else if (started_reg >= TOKEN_LIMIT)
                    begin
                        push             = 1'b1;
                        push_entry.op    = OP_DONE;
                        push_entry.total = TOKEN_LIMIT;
                        push_entry.trunc = 1'b1;
                        started_next     = '0;
                        mode_next        = MODE_DISCARD;
                    end
                    else
                    begin
                        started_next = started_reg + 1'b1;
                        if (quote)
                        begin
                            mode_next = MODE_QUOTE;
                        end
                        else
                        begin
                            mode_next         = MODE_TOKEN;
                            push              = 1'b1;
                            push_entry.op     = OP_CHAR;
                            push_entry.ch     = character;
                            push_entry.number = started_reg;
                        end
                    end
                end
                MODE_TOKEN:
                begin
                    if (eol)
                    begin
                        push              = 1'b1;
                        push_entry.op     = OP_END_DONE;
                        push_entry.number = cur;
                        push_entry.total  = started_reg;
                        started_next      = '0;
                        mode_next         = MODE_SKIP;
                    end
                    else if (sep)
                    begin
                        push              = 1'b1;
                        push_entry.op     = OP_END;
                        push_entry.number = cur;
                        mode_next         = MODE_SKIP;
                    end
                    else if (quote)
                    begin
                        mode_next = MODE_QUOTE;
                    end
                    else
                    begin
                        push              = 1'b1;
                        push_entry.op     = OP_CHAR;
                        push_entry.ch     = character;
                        push_entry.number = cur;
                    end
                end
                MODE_QUOTE:
                begin
                    if (eol)
                    begin
                        push              = 1'b1;
                        push_entry.op     = OP_END_DONE;
                        push_entry.number = cur;
                        push_entry.total  = started_reg;
                        started_next      = '0;
                        mode_next         = MODE_SKIP;
                    end
                    else if (quote)
                    begin
                        mode_next = MODE_TOKEN;
                    end
                    else
                    begin
                        push              = 1'b1;
                        push_entry.op     = OP_CHAR;
                        push_entry.ch     = character;
                        push_entry.number = cur;
                    end
                end
                MODE_DISCARD:
                begin
                    if (eol)
                    begin
                        started_next = '0;
                        mode_next    = MODE_SKIP;
                    end
                end
                default:
                begin
                    started_next = '0;
                    mode_next    = MODE_SKIP;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SKIP;
            started_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            started_reg <= started_next;
        end
    end

endmodule

// ----- src/qat_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_queue
// Short FIFO of result operations between the front and the back.
// ----------------------------------------------------------------------------
module qat_queue
    import qat_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output entry_t head
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/qat_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_back
// Expands queued operations into result items and holds them in the
// output register until taken.
// ----------------------------------------------------------------------------
module qat_back
    import qat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  entry_t             head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         token_char,
    output logic [TOKEN_W-1:0] token_number,
    output logic [TOKEN_W-1:0] token_total,
    output logic               truncated,
    output logic               last
);

    logic               valid_reg, valid_next;
    logic               phase_reg, phase_next;
    logic               load;
    logic [1:0]         kind_reg, kind_next;
    logic [7:0]         char_reg, char_next;
    logic [TOKEN_W-1:0] number_reg, number_next;
    logic [TOKEN_W-1:0] total_reg, total_next;
    logic               trunc_reg, trunc_next;
    logic               last_reg, last_next;

    assign load = !valid_reg || !out_stall;

    // Result selection; a token end before line done takes two items
    always_comb
    begin
        valid_next  = valid_reg;
        phase_next  = phase_reg;
        pop         = 1'b0;
        kind_next   = kind_reg;
        char_next   = char_reg;
        number_next = number_reg;
        total_next  = total_reg;
        trunc_next  = trunc_reg;
        last_next   = last_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                char_next   = '0;
                number_next = '0;
                total_next  = '0;
                trunc_next  = 1'b0;
                last_next   = 1'b1;
                pop         = 1'b1;
                case (head.op)
                    OP_CHAR:
                    begin
                        kind_next   = KIND_CHAR;
                        char_next   = head.ch;
                        number_next = head.number;
                    end
                    OP_END:
                    begin
                        kind_next   = KIND_END;
                        number_next = head.number;
                    end
                    OP_DONE:
                    begin
                        kind_next  = KIND_DONE;
                        total_next = head.total;
                        trunc_next = head.trunc;
                    end
                    OP_END_DONE:
                    begin
                        if (!phase_reg)
                        begin
                            kind_next   = KIND_END;
                            number_next = head.number;
                            last_next   = 1'b0;
                            pop         = 1'b0;
                            phase_next  = 1'b1;
                        end
                        else
                        begin
                            kind_next  = KIND_DONE;
                            total_next = head.total;
                            phase_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        kind_next = KIND_CHAR;
                    end
                endcase
            end
        end
    end

    // Output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        char_reg   <= char_next;
        number_reg <= number_next;
        total_reg  <= total_next;
        trunc_reg  <= trunc_next;
        last_reg   <= last_next;
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign token_char   = char_reg;
    assign token_number = number_reg;
    assign token_total  = total_reg;
    assign truncated    = trunc_reg;
    assign last         = last_reg;

endmodule

// ----- src/quoted_argument_tokenizer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_unit
// Splits a character stream into quoted or plain tokens.
// ----------------------------------------------------------------------------
// Path: an item's results pass the queue slot, then the output register.
// Throughput: one item per cycle unless in_stall or out_stall holds; a line
// end that closes a token yields two result items from the 4-entry queue.
// Reset: scan mode, token count, queue and output valid clear; the extra
// separator returns to space.
module quoted_argument_tokenizer_unit
    import qat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    // character input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         character,
    // result output
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         token_char,
    output logic [TOKEN_W-1:0] token_number,
    output logic [TOKEN_W-1:0] token_total,
    output logic               truncated,
    output logic               last
);

    logic   accept;
    logic   push, pop, full, empty;
    entry_t push_entry, head;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !in_stall;

    qat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .character  (character),
        .push       (push),
        .push_entry (push_entry)
    );

    qat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    qat_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .token_char   (token_char),
        .token_number (token_number),
        .token_total  (token_total),
        .truncated    (truncated),
        .last         (last)
    );

endmodule
